FILE: sv/ctk_pkg.sv
`default_nettype none
package ctk_pkg;

    // Widths of position, length and literal value
    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 16;
    localparam int VAL_BITS = 31;

    // Result word layout on the stream bus
    localparam int DATA_BITS = 4 + 2 + POS_BITS + LEN_BITS + VAL_BITS;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    // Scanner modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_MINUS  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_WORD   = 3'd3;
    localparam logic [2:0] MODE_DRAIN  = 3'd4;

    // Token kinds
    localparam logic [3:0] K_LPAREN = 4'd0;
    localparam logic [3:0] K_RPAREN = 4'd1;
    localparam logic [3:0] K_LBRACE = 4'd2;
    localparam logic [3:0] K_RBRACE = 4'd3;
    localparam logic [3:0] K_SEMI   = 4'd4;
    localparam logic [3:0] K_MINUS  = 4'd5;
    localparam logic [3:0] K_MINUS2 = 4'd6;
    localparam logic [3:0] K_TILDE  = 4'd7;
    localparam logic [3:0] K_INT    = 4'd8;
    localparam logic [3:0] K_VOID   = 4'd9;
    localparam logic [3:0] K_RETURN = 4'd10;
    localparam logic [3:0] K_IDENT  = 4'd11;
    localparam logic [3:0] K_INTLIT = 4'd12;
    localparam logic [3:0] K_EOF    = 4'd13;
    localparam logic [3:0] K_ERROR  = 4'd14;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_LIT_WORD = 2'd3;

    // Keyword spellings, last byte lowest
    localparam logic [47:0] KW_INT    = 48'h0000_0069_6E74;
    localparam logic [47:0] KW_VOID   = 48'h0000_766F_6964;
    localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [3:0]          kind;
        logic [1:0]          err;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] len;
        logic [VAL_BITS-1:0] val;
        logic                last;
    } tok_t;

    typedef struct packed {
        logic [1:0] cnt;
        tok_t       t0;
        tok_t       t1;
    } scan_res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122))
            || (c == 8'd95);
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] kind, input logic [1:0] err,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [LEN_BITS-1:0] len,
                                    input logic [VAL_BITS-1:0] val);
        tok_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = start;
        t.len   = len;
        t.val   = val;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: sv/c_subset_tokenizer.sv
`default_nettype none
// Tokenizer for a small subset of C. Source bytes enter on the slave stream,
// one per word, with tuser high on a word that marks the end of the text;
// tokens leave on the master stream, one per word, with tlast on the final
// token caused by an input word. Each input word is registered, then scanned,
// and its zero, one or two tokens are written to a four-entry result queue.
// One input word is taken per cycle while the queue holds at most two
// tokens; a byte that both closes a pending token and forms one of its own
// yields two tokens, and the master port drains at most one per cycle, so a
// steady stream of such bytes is taken below that rate. After an error token
// the scanner drops bytes until the end marker, which flushes any pending
// token, emits eof and resets the byte position to zero.
module c_subset_tokenizer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // ch
    input  wire logic                        s_tuser,  // text_end
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // kind, error_code, start_pos, length, int_value
    output logic [ctk_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast
);
    import ctk_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_ch_reg;
    logic             in_end_reg;
    logic             fifo_room;
    logic             proc_fire;
    logic [1:0]       push_cnt;
    scan_res_t        scan_res;
    tok_t             head;
    logic [CNT_W-1:0] fifo_count;
    logic             pop;

    assign fifo_room = fifo_count <= CNT_W'(FIFO_DEPTH - 2);
    assign proc_fire = in_valid_reg && fifo_room;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign push_cnt  = proc_fire ? scan_res.cnt : 2'd0;
    assign pop       = m_tvalid && m_tready;

    // Input register: hold a word until the scanner takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_end_reg <= s_tuser;
        end
    end

    ctk_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (proc_fire),
        .ch       (in_ch_reg),
        .text_end (in_end_reg),
        .res      (scan_res)
    );

    ctk_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (scan_res.t0),
        .push1    (scan_res.t1),
        .pop      (pop),
        .head     (head),
        .count    (fifo_count)
    );

    // Drive the result stream from the queue head
    assign m_tvalid = fifo_count != '0;
    assign m_tdata  = TDATA_W'({head.val, head.len, head.start, head.err, head.kind});
    assign m_tlast  = head.last;

    // Queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // The end marker always produces at least the eof token
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_end_reg) |-> (scan_res.cnt != 2'd0))
        else $error("end marker produced no token");

    // Of two tokens, only the second carries tlast
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && (scan_res.cnt == 2'd2)) |-> (!scan_res.t0.last && scan_res.t1.last))
        else $error("tlast misplaced on token pair");

    // A stalled input word holds until scanned
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(in_ch_reg)
                                          && $stable(in_end_reg)))
        else $error("stalled input word lost");

endmodule
`default_nettype wire

FILE: sv/ctk_scan.sv
`default_nettype none
module ctk_scan (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        ch,
    input  wire logic              text_end,
    output ctk_pkg::scan_res_t     res
);
    import ctk_pkg::*;

    logic [2:0]          mode_reg,   mode_next;
    logic [POS_BITS-1:0] pos_reg,    pos_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [VAL_BITS-1:0] acc_reg,    acc_next;
    logic [LEN_BITS-1:0] wlen_reg,   wlen_next;
    logic [47:0]         kchars_reg, kchars_next;

    logic [LEN_BITS-1:0] wlen_bump;
    logic [3:0]          digit;
    logic [VAL_BITS+3:0] lit_sum;
    logic                lit_ovf;
    logic                flush_v;
    tok_t                flush_tok;
    logic [3:0]          word_kind;
    logic                do_start;
    logic                a_v, b_v;
    tok_t                a_tok, b_tok;

    // Saturating length and next literal value
    assign wlen_bump = (wlen_reg == '1) ? wlen_reg : wlen_reg + 1'b1;
    assign digit     = 4'(ch - CH_ZERO);
    assign lit_sum   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{VAL_BITS{1'b0}}, digit};
    assign lit_ovf   = |lit_sum[VAL_BITS+3:VAL_BITS];

    // Keyword match on the word held so far
    always_comb begin
        word_kind = K_IDENT;
        if ((wlen_reg == LEN_BITS'(3)) && (kchars_reg == KW_INT)) begin
            word_kind = K_INT;
        end else if ((wlen_reg == LEN_BITS'(4)) && (kchars_reg == KW_VOID)) begin
            word_kind = K_VOID;
        end else if ((wlen_reg == LEN_BITS'(6)) && (kchars_reg == KW_RETURN)) begin
            word_kind = K_RETURN;
        end
    end

    // Pending token that a closing byte or the end marker flushes
    always_comb begin
        flush_v   = 1'b0;
        flush_tok = mk_tok(K_IDENT, ERR_NONE, tstart_reg, wlen_reg, '0);
        unique case (mode_reg)
            MODE_MINUS: begin
                flush_v   = 1'b1;
                flush_tok = mk_tok(K_MINUS, ERR_NONE, tstart_reg, LEN_BITS'(1), '0);
            end
            MODE_NUMBER: begin
                flush_v   = 1'b1;
                flush_tok = mk_tok(K_INTLIT, ERR_NONE, tstart_reg, wlen_reg, acc_reg);
            end
            MODE_WORD: begin
                flush_v   = 1'b1;
                flush_tok = mk_tok(word_kind, ERR_NONE, tstart_reg, wlen_reg, '0);
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase
    end

    // Step the scanner by one byte or the end marker
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        acc_next    = acc_reg;
        wlen_next   = wlen_reg;
        kchars_next = kchars_reg;
        a_v         = 1'b0;
        a_tok       = flush_tok;
        b_v         = 1'b0;
        b_tok       = mk_tok(K_EOF, ERR_NONE, pos_reg, '0, '0);
        do_start    = 1'b0;

        if (text_end) begin
            a_v         = flush_v;
            b_v         = 1'b1;
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            acc_next    = '0;
            wlen_next   = '0;
            kchars_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
            unique case (mode_reg)
                MODE_DRAIN: begin
                    mode_next = MODE_DRAIN;
                end
                MODE_MINUS: begin
                    if (ch == CH_MINUS) begin
                        b_v       = 1'b1;
                        b_tok     = mk_tok(K_MINUS2, ERR_NONE, tstart_reg, LEN_BITS'(2), '0);
                        mode_next = MODE_IDLE;
                    end else begin
                        a_v      = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(ch)) begin
                        wlen_next = wlen_bump;
                        if (lit_ovf) begin
                            b_v       = 1'b1;
                            b_tok     = mk_tok(K_ERROR, ERR_OVERFLOW, tstart_reg, wlen_bump, '0);
                            mode_next = MODE_DRAIN;
                        end else begin
                            acc_next = lit_sum[VAL_BITS-1:0];
                        end
                    end else if (is_alpha(ch)) begin
                        wlen_next = wlen_bump;
                        b_v       = 1'b1;
                        b_tok     = mk_tok(K_ERROR, ERR_LIT_WORD, tstart_reg, wlen_bump, '0);
                        mode_next = MODE_DRAIN;
                    end else begin
                        a_v      = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_alpha(ch) || is_digit(ch)) begin
                        wlen_next   = wlen_bump;
                        kchars_next = {kchars_reg[39:0], ch};
                    end else begin
                        a_v      = 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // Open a new token with this byte
            if (do_start) begin
                mode_next = MODE_IDLE;
                if (!is_space(ch)) begin
                    tstart_next = pos_reg;
                    priority if (ch == 8'h28) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_LPAREN, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == 8'h29) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_RPAREN, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == 8'h7B) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_LBRACE, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == 8'h7D) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_RBRACE, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == 8'h3B) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_SEMI, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == 8'h7E) begin
                        b_v   = 1'b1;
                        b_tok = mk_tok(K_TILDE, ERR_NONE, pos_reg, LEN_BITS'(1), '0);
                    end else if (ch == CH_MINUS) begin
                        mode_next = MODE_MINUS;
                    end else if (is_digit(ch)) begin
                        mode_next = MODE_NUMBER;
                        acc_next  = VAL_BITS'(digit);
                        wlen_next = LEN_BITS'(1);
                    end else if (is_alpha(ch)) begin
                        mode_next   = MODE_WORD;
                        kchars_next = {40'd0, ch};
                        wlen_next   = LEN_BITS'(1);
                    end else begin
                        b_v       = 1'b1;
                        b_tok     = mk_tok(K_ERROR, ERR_BAD_CHAR, pos_reg, LEN_BITS'(1), '0);
                        mode_next = MODE_DRAIN;
                    end
                end
            end
        end
    end

    // Pack the results in order, marking the final one
    always_comb begin
        res.cnt     = 2'({1'b0, a_v} + {1'b0, b_v});
        res.t0      = a_v ? a_tok : b_tok;
        res.t0.last = !(a_v && b_v);
        res.t1      = b_tok;
        res.t1.last = 1'b1;
    end

    // Advance scanner state on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            acc_reg    <= '0;
            wlen_reg   <= '0;
            kchars_reg <= '0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            acc_reg    <= acc_next;
            wlen_reg   <= wlen_next;
            kchars_reg <= kchars_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ctk_fifo.sv
`default_nettype none
module ctk_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [1:0]             push_cnt,
    input  wire ctk_pkg::tok_t          push0,
    input  wire ctk_pkg::tok_t          push1,
    input  wire logic                   pop,
    output ctk_pkg::tok_t               head,
    output logic [ctk_pkg::CNT_W-1:0]   count
);
    import ctk_pkg::*;

    tok_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [FIFO_AW-1:0] wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

    // Store up to two result words per cycle
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: dv/tb_c_subset_tokenizer.sv
module tb_c_subset_tokenizer;
    import ctk_pkg::*;

    // Field offsets in the result word, lowest field first
    localparam int OFF_ERR   = 4;
    localparam int OFF_START = OFF_ERR + 2;
    localparam int OFF_LEN   = OFF_START + POS_BITS;
    localparam int OFF_VAL   = OFF_LEN + LEN_BITS;

    localparam logic [63:0] LIT_LIMIT = 64'h7FFF_FFFF;
    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } src_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;   // ch
    logic                 s_tuser = 1'b0;    // text_end
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // kind, error_code, start_pos, length, int_value
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    c_subset_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    src_word_t source_words[$];
    tok_t      tokens_due[$];

    // Scanner state as the tokenizer should hold it
    logic [2:0]          scan_mode = MODE_IDLE;
    logic [POS_BITS-1:0] next_pos = '0;
    logic [POS_BITS-1:0] tok_start = '0;
    logic [VAL_BITS-1:0] lit_acc = '0;
    logic [LEN_BITS-1:0] word_len = '0;
    logic [47:0]         word_tail = '0;

    int  total_words;
    int  words_in;
    int  tokens_checked;
    int  error_tokens;
    int  keyword_tokens;
    int  texts_sent;
    int  fails;
    bit  text_broken;
    bit  byte_taken;
    int  burst_left;
    int  gap_left;
    int  hold_left;
    bit  hold_done;
    int  rx_cycle;
    int  rx_style;

    // Clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic blank_byte(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic punct_byte(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == ";" || c == "~"
            || c == CH_MINUS;
    endfunction

    function automatic void add_token(input logic [3:0] kind, input logic [1:0] code,
                                      input logic [POS_BITS-1:0] at,
                                      input logic [LEN_BITS-1:0] len,
                                      input logic [VAL_BITS-1:0] val);
        tok_t t;
        t.kind  = kind;
        t.err   = code;
        t.start = at;
        t.len   = len;
        t.val   = val;
        t.last  = 1'b0;
        tokens_due.push_back(t);
    endfunction

    function automatic void clear_scanner();
        scan_mode = MODE_IDLE;
        next_pos  = '0;
        tok_start = '0;
        lit_acc   = '0;
        word_len  = '0;
        word_tail = '0;
    endfunction

    function automatic void bump_word_len();
        if (word_len != '1) word_len = word_len + 1'b1;
    endfunction

    // Emit whatever token is still open
    function automatic void close_token();
        logic [3:0] kind;
        case (scan_mode)
            MODE_MINUS:  add_token(K_MINUS, ERR_NONE, tok_start, LEN_BITS'(1), '0);
            MODE_NUMBER: add_token(K_INTLIT, ERR_NONE, tok_start, word_len, lit_acc);
            MODE_WORD: begin
                kind = K_IDENT;
                if (word_len == 3 && word_tail == KW_INT) kind = K_INT;
                else if (word_len == 4 && word_tail == KW_VOID) kind = K_VOID;
                else if (word_len == 6 && word_tail == KW_RETURN) kind = K_RETURN;
                add_token(kind, ERR_NONE, tok_start, word_len, '0);
            end
            default: ;
        endcase
        scan_mode = MODE_IDLE;
    endfunction

    // Treat a byte as the first of a new token
    function automatic void open_token(input logic [7:0] c, input logic [POS_BITS-1:0] at);
        if (blank_byte(c)) return;
        tok_start = at;
        case (c)
            "(":      add_token(K_LPAREN, ERR_NONE, at, LEN_BITS'(1), '0);
            ")":      add_token(K_RPAREN, ERR_NONE, at, LEN_BITS'(1), '0);
            "{":      add_token(K_LBRACE, ERR_NONE, at, LEN_BITS'(1), '0);
            "}":      add_token(K_RBRACE, ERR_NONE, at, LEN_BITS'(1), '0);
            ";":      add_token(K_SEMI, ERR_NONE, at, LEN_BITS'(1), '0);
            "~":      add_token(K_TILDE, ERR_NONE, at, LEN_BITS'(1), '0);
            CH_MINUS: scan_mode = MODE_MINUS;
            default: begin
                if (digit_byte(c)) begin
                    scan_mode = MODE_NUMBER;
                    lit_acc   = VAL_BITS'(c - CH_ZERO);
                    word_len  = LEN_BITS'(1);
                end else if (word_byte(c)) begin
                    scan_mode = MODE_WORD;
                    word_tail = {40'd0, c};
                    word_len  = LEN_BITS'(1);
                end else begin
                    add_token(K_ERROR, ERR_BAD_CHAR, at, LEN_BITS'(1), '0);
                    scan_mode = MODE_DRAIN;
                end
            end
        endcase
    endfunction

    // Work out the tokens that one accepted input word causes
    function automatic void scan_byte(input logic [7:0] c, input logic eot);
        int                  prior;
        logic [POS_BITS-1:0] here;
        logic [63:0]         v;
        tok_t                t;
        prior = tokens_due.size();
        here  = next_pos;
        if (eot) begin
            if (scan_mode != MODE_DRAIN) close_token();
            add_token(K_EOF, ERR_NONE, here, '0, '0);
            clear_scanner();
        end else begin
            next_pos = here + 1'b1;
            case (scan_mode)
                MODE_DRAIN: ;
                MODE_MINUS: begin
                    if (c == CH_MINUS) begin
                        add_token(K_MINUS2, ERR_NONE, tok_start, LEN_BITS'(2), '0);
                        scan_mode = MODE_IDLE;
                    end else begin
                        close_token();
                        open_token(c, here);
                    end
                end
                MODE_NUMBER: begin
                    if (digit_byte(c)) begin
                        v = 64'(lit_acc) * 64'd10 + 64'(c - CH_ZERO);
                        bump_word_len();
                        if (v > LIT_LIMIT) begin
                            add_token(K_ERROR, ERR_OVERFLOW, tok_start, word_len, '0);
                            scan_mode = MODE_DRAIN;
                        end else begin
                            lit_acc = v[VAL_BITS-1:0];
                        end
                    end else if (word_byte(c)) begin
                        bump_word_len();
                        add_token(K_ERROR, ERR_LIT_WORD, tok_start, word_len, '0);
                        scan_mode = MODE_DRAIN;
                    end else begin
                        close_token();
                        open_token(c, here);
                    end
                end
                MODE_WORD: begin
                    if (word_byte(c) || digit_byte(c)) begin
                        bump_word_len();
                        word_tail = {word_tail[39:0], c};
                    end else begin
                        close_token();
                        open_token(c, here);
                    end
                end
                default: begin
                    scan_mode = MODE_IDLE;
                    open_token(c, here);
                end
            endcase
        end
        // Mark the final token of this word
        if (tokens_due.size() > prior) begin
            t = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Stimulus building
    function automatic void put_byte(input logic [7:0] c);
        src_word_t w;
        w.ch  = c;
        w.eot = 1'b0;
        source_words.push_back(w);
    endfunction

    function automatic void put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_end();
        src_word_t w;
        w.ch  = 8'($urandom_range(0, 255));
        w.eot = 1'b1;
        source_words.push_back(w);
    endfunction

    function automatic logic [7:0] pick_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] pick_bad_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (blank_byte(c) || digit_byte(c) || word_byte(c) || punct_byte(c));
        return c;
    endfunction

    // Append one token's text; flag the text when it ends in an error
    function automatic int put_random_token();
        int              queued;
        int              pick;
        int              n;
        int              i;
        string           punct;
        longint unsigned v;
        queued = source_words.size();
        pick   = $urandom_range(0, 99);
        punct  = "(){};~";
        text_broken = 1'b0;
        if (pick < 20) begin
            put_byte(punct[$urandom_range(0, 5)]);
        end else if (pick < 30) begin
            if ($urandom_range(0, 1) != 0) put_text("--");
            else put_text("-");
        end else if (pick < 45) begin
            case ($urandom_range(0, 2))
                0:       put_text("int");
                1:       put_text("void");
                default: put_text("return");
            endcase
        end else if (pick < 65) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0:       put_text("in");
                    1:       put_text("inte");
                    2:       put_text("vo");
                    3:       put_text("voids");
                    4:       put_text("retur");
                    5:       put_text("Return");
                    6:       put_text("int_");
                    default: put_text("_void");
                endcase
            end else begin
                n = $urandom_range(1, 8);
                put_byte(pick_alpha());
                for (i = 1; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) put_byte(8'("0" + $urandom_range(0, 9)));
                    else put_byte(pick_alpha());
                end
            end
        end else if (pick < 88) begin
            case ($urandom_range(0, 4))
                0:       v = $urandom_range(0, 9);
                1:       v = $urandom_range(0, 99999);
                2:       v = $urandom() & 32'h7FFF_FFFF;
                3:       v = 64'd2147483647 - $urandom_range(0, 20);
                default: v = 64'd2147483647;
            endcase
            if ($urandom_range(0, 7) == 0) put_text("00");
            put_text($sformatf("%0d", v));
        end else if (pick < 92) begin
            // value just past the limit, or far past it
            if ($urandom_range(0, 1) == 0) v = 64'd2147483648 + $urandom_range(0, 1000);
            else v = 64'd2147483648 + 64'($urandom()) * $urandom_range(1, 9);
            put_text($sformatf("%0d", v));
            text_broken = 1'b1;
        end else if (pick < 96) begin
            put_text($sformatf("%0d", $urandom_range(0, 99999)));
            put_byte(pick_alpha());
            text_broken = 1'b1;
        end else begin
            put_byte(pick_bad_byte());
            text_broken = 1'b1;
        end
        return source_words.size() - queued;
    endfunction

    // Fill the stimulus queue: directed texts, then random texts
    function automatic void build_stimulus();
        int    counted;
        int    ntok;
        int    i;
        int    style;
        string blanks;
        blanks = " \t\n\013\014\r";
        // every punctuator except minus, with a space and a tab among them
        put_text("( ){\t};~");
        put_end();
        // a minus pair and a trailing single minus before a word
        put_text("---a");
        put_end();
        // literal closed by an invalid byte
        put_text("0@");
        put_end();
        // literal running into a letter
        put_text("9z");
        put_end();
        // top-bit byte as the whole text
        put_byte(8'hFF);
        put_end();
        texts_sent = 5;

        counted = 0;
        while (counted < RANDOM_BYTES) begin
            texts_sent++;
            style = $urandom_range(0, 19);
            if (style == 1) begin
                ntok = $urandom_range(1, 12);
                repeat (ntok) put_byte(8'($urandom_range(0, 255)));
                counted += ntok;
            end else if (style != 0) begin
                ntok = $urandom_range(1, 12);
                text_broken = 1'b0;
                for (i = 0; i < ntok && !text_broken; i++) begin
                    counted += put_random_token();
                    if (text_broken) begin
                        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
                    end else if ($urandom_range(0, 2) != 0) begin
                        repeat ($urandom_range(1, 2)) put_byte(blanks[$urandom_range(0, 5)]);
                    end
                end
            end
            put_end();
            counted++;
        end

        // short closing text
        put_text("return 7;");
        put_end();
        texts_sent += 1;
    endfunction

    // Reset and end of run
    initial begin
        build_stimulus();
        total_words = source_words.size();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        while (words_in != total_words) @(negedge aclk);
        while (tokens_due.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        $display("Covered %0d texts in %0d input words; %0d tokens checked,",
                 texts_sent, words_in, tokens_checked);
        $display("  %0d of them errors and %0d keywords.", error_tokens, keyword_tokens);
        if (fails == 0 && tokens_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $error("timeout with %0d tokens outstanding", tokens_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Source side: bursts of words with random gaps
    always @(negedge aclk) begin : drive_source
        src_word_t w;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= $urandom_range(1, 48);
            gap_left   <= 0;
        end else if (!s_tvalid || byte_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (source_words.size() != 0) begin
                w = source_words.pop_front();
                s_tdata  <= w.ch;
                s_tuser  <= w.eot;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: changing stall pattern, and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
            rx_cycle  <= 0;
            rx_style  <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && tokens_checked >= 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 50 == 0) rx_style <= $urandom_range(0, 3);
            case (rx_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_cycle[0];
            endcase
        end
    end

    // Predict on accepted source words, check accepted tokens
    always @(posedge aclk) begin : watch_ports
        tok_t want;
        tok_t got;
        if (!aresetn) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tuser);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                got.kind  = m_tdata[3:0];
                got.err   = m_tdata[OFF_ERR +: 2];
                got.start = m_tdata[OFF_START +: POS_BITS];
                got.len   = m_tdata[OFF_LEN +: LEN_BITS];
                got.val   = m_tdata[OFF_VAL +: VAL_BITS];
                got.last  = m_tlast;
                if (tokens_due.size() == 0) begin
                    $error("token of kind %0d at %0d with none expected",
                           got.kind, got.start);
                    fails++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("kind", 64'(want.kind), 64'(got.kind));
                    check_field("error_code", 64'(want.err), 64'(got.err));
                    check_field("start_pos", 64'(want.start), 64'(got.start));
                    check_field("length", 64'(want.len), 64'(got.len));
                    check_field("int_value", 64'(want.val), 64'(got.val));
                    check_field("last", 64'(want.last), 64'(got.last));
                    if (want.kind == K_ERROR) error_tokens++;
                    if (want.kind == K_INT || want.kind == K_VOID || want.kind == K_RETURN)
                        keyword_tokens++;
                end
                tokens_checked++;
            end
        end
    end

endmodule

FILE: sim.f
sv/ctk_pkg.sv
sv/ctk_scan.sv
sv/ctk_fifo.sv
sv/c_subset_tokenizer.sv
dv/tb_c_subset_tokenizer.sv
